### hw/rtl/xy_table_linear_interpolator_defines.svh
// shared assertion macros for the interpolator checks
`ifndef XY_TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define XY_TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, muted during reset
`define XYLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, muted during reset
`define XYLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/xyli_pkg.sv
package xyli_pkg;

  // operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_DIR,
    S_SCAN,
    S_MUL,
    S_DIV_GO,
    S_DIV
  } state_t;

  // table read address source
  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_SCAN
  } addr_sel_t;

  typedef struct packed {
    logic      wr_pt;
    logic      capture;
    addr_sel_t addr_sel;
    logic      cap_first;
    logic      set_dir;
    logic      scan_step;
    logic      load_ops;
    logic      mul;
    logic      div_start;
    logic      emit_direct;
    logic      emit_div;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic direct;
    logic div_done;
  } status_t;

endpackage

### hw/rtl/xyli_ram.sv
module xyli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/xyli_div.sv
module xyli_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start_i,
  input  logic signed [33:0] num_i,
  input  logic signed [16:0] den_i,
  output logic signed [16:0] quo_o,
  output logic               done_o
);

  // quotient magnitude stays below 2^16, so sixteen restoring steps suffice
  localparam int STEPS = 16;
  localparam int CNT_W = $clog2(STEPS);

  logic [32:0]      num_mag;
  logic [16:0]      den_mag;
  logic [16:0]      rem_r, rem_nxt;
  logic [15:0]      quo_r, quo_nxt;
  logic [16:0]      den_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [17:0]      trial;
  logic [17:0]      diff;
  logic             ge;

  always_comb begin
    num_mag = num_i[33] ? 33'(-num_i) : 33'(num_i);
    den_mag = den_i[16] ? 17'(-den_i) : 17'(den_i);
    trial   = {rem_r, quo_r[15]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[16:0] : trial[16:0];
    quo_nxt = {quo_r[14:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= num_mag[32:16];
      quo_r <= num_mag[15:0];
      den_r <= den_mag;
      neg_r <= num_i[33] ^ den_i[16];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo_o  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign done_o = done_r;

endmodule

### hw/rtl/xyli_ctrl.sv
module xyli_ctrl import xyli_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    op_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && op_i == OP_QUERY) begin
          state_nxt = S_RD_FIRST;
        end
      end
      S_RD_FIRST: state_nxt = S_RD_LAST;
      S_RD_LAST:  state_nxt = S_DIR;
      S_DIR:      state_nxt = S_SCAN;
      S_SCAN: begin
        if (status_i.stop) begin
          state_nxt = status_i.direct ? S_IDLE : S_MUL;
        end
      end
      S_MUL:    state_nxt = S_DIV_GO;
      S_DIV_GO: state_nxt = S_DIV;
      S_DIV: begin
        if (status_i.div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_ZERO;
    unique case (state_r)
      S_IDLE: begin
        cmd_o.wr_pt   = start && op_i == OP_WRITE;
        cmd_o.capture = start && op_i == OP_QUERY;
      end
      S_RD_FIRST: cmd_o.addr_sel = ADDR_ZERO;
      S_RD_LAST: begin
        cmd_o.addr_sel  = ADDR_LAST;
        cmd_o.cap_first = 1'b1;
      end
      S_DIR: begin
        cmd_o.addr_sel = ADDR_ZERO;
        cmd_o.set_dir  = 1'b1;
      end
      S_SCAN: begin
        cmd_o.addr_sel    = ADDR_SCAN;
        cmd_o.scan_step   = 1'b1;
        cmd_o.emit_direct = status_i.stop && status_i.direct;
        cmd_o.load_ops    = status_i.stop && !status_i.direct;
      end
      S_MUL:    cmd_o.mul = 1'b1;
      S_DIV_GO: cmd_o.div_start = 1'b1;
      S_DIV:    cmd_o.emit_div = status_i.div_done;
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = state_r != S_IDLE;

endmodule

### hw/rtl/xyli_dp.sv
module xyli_dp import xyli_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [3:0]         in_point_index,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_query_x,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  output logic               out_valid,
  output logic signed [15:0] out_result_y
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic [4:0] PIU_RESET = 5'd2;

  logic [4:0]         piu_r;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [IDX_W-1:0]   c_r;
  logic [IDX_W-1:0]   raddr;
  logic               wr_ok;
  logic [31:0]        rd_data;
  logic signed [15:0] rd_x, rd_y;
  logic signed [15:0] qx_r;
  logic signed [15:0] first_x_r;
  logic               rising_r;
  logic signed [15:0] prev_x_r, prev_y_r;
  logic signed [16:0] dy_r, dx_r, den_r;
  logic signed [15:0] y0_r;
  logic signed [33:0] prod_r;
  logic signed [16:0] quo;
  logic               div_done;
  logic signed [16:0] sum;
  logic               past, at_last, end_ok;
  logic               out_valid_r;
  logic signed [15:0] result_r;

  // breakpoint count in use, clamped to 1..MAX_POINTS
  always_comb begin
    int unsigned n;
    n = 32'(piu_r);
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    last_nxt = IDX_W'(n - 1);
  end

  assign wr_ok = cmd_i.wr_pt && (32'(in_point_index) < MAX_POINTS);

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_ZERO: raddr = '0;
      ADDR_LAST: raddr = last_r;
      ADDR_SCAN: raddr = c_r + IDX_W'(1);
      default:   raddr = '0;
    endcase
  end

  xyli_ram #(
    .WIDTH(32),
    .DEPTH(MAX_POINTS)
  ) u_tbl (
    .clk  (clk),
    .we   (wr_ok),
    .waddr(IDX_W'(in_point_index)),
    .wdata({in_point_x, in_point_y}),
    .raddr(raddr),
    .rdata(rd_data)
  );

  assign rd_x = $signed(rd_data[31:16]);
  assign rd_y = $signed(rd_data[15:0]);

  always_comb begin
    past    = rising_r ? (rd_x > qx_r) : (rd_x < qx_r);
    at_last = c_r == last_r;
    end_ok  = rising_r ? (qx_r >= rd_x) : (qx_r <= rd_x);
    status_o.stop     = at_last || past;
    status_o.direct   = (c_r == '0) || (at_last && end_ok);
    status_o.div_done = div_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r       <= PIU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        piu_r <= cfg_wdata;
      end
      out_valid_r <= cmd_i.emit_direct || cmd_i.emit_div;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      qx_r   <= in_query_x;
      last_r <= last_nxt;
    end
    if (cmd_i.cap_first) begin
      first_x_r <= rd_x;
    end
    if (cmd_i.set_dir) begin
      rising_r <= first_x_r < rd_x;
      c_r      <= '0;
    end
    if (cmd_i.scan_step) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
      c_r      <= c_r + IDX_W'(1);
    end
    if (cmd_i.load_ops) begin
      dy_r <= $signed({rd_y[15], rd_y}) - $signed({prev_y_r[15], prev_y_r});
      dx_r <= $signed({qx_r[15], qx_r}) - $signed({prev_x_r[15], prev_x_r});
      den_r <= $signed({rd_x[15], rd_x}) - $signed({prev_x_r[15], prev_x_r});
      y0_r <= prev_y_r;
    end
    if (cmd_i.mul) begin
      prod_r <= dy_r * dx_r;
    end
    if (cmd_i.emit_direct) begin
      result_r <= rd_y;
    end else if (cmd_i.emit_div) begin
      result_r <= sum[15:0];
    end
  end

  xyli_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(cmd_i.div_start),
    .num_i  (prod_r),
    .den_i  (den_r),
    .quo_o  (quo),
    .done_o (div_done)
  );

  assign sum          = $signed({y0_r[15], y0_r}) + quo;
  assign out_valid    = out_valid_r;
  assign out_result_y = result_r;

endmodule

### hw/rtl/xy_table_linear_interpolator.sv
// write item: taken in the cycle it is presented, busy stays low, no result
// query item: the strobe follows the one-entry-a-cycle table scan and, where no end point
//   is returned, the 16-step restoring divider
// one query at a time; the next item may be taken in the strobe cycle
// synchronous active-low reset: idle, points_in_use = 2, table contents undefined
module xy_table_linear_interpolator import xyli_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [3:0]         in_point_index,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_query_x,
  // result channel, one-cycle strobe
  output logic               out_valid,
  output logic signed [15:0] out_result_y,
  // points_in_use register
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  // sequencer: reads first and last entry to set the column direction,
  // then scans from entry 0 until the first breakpoint past the query or the last entry in use
  xyli_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op_i    (in_operation),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath: breakpoint ram (one write, one registered read port),
  // scan compare, 17x17 multiply and the divider
  xyli_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_point_index(in_point_index),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_query_x    (in_query_x),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_result_y  (out_result_y)
  );

endmodule

### hw/rtl/xyli_checker.sv
`include "xy_table_linear_interpolator_defines.svh"

module xyli_checker import xyli_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_operation,
  input logic out_valid
);

  `XYLI_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held longer than one cycle")
  `XYLI_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while still busy")
  `XYLI_ASSERT_NEXT(a_query_busy, start && !busy && in_operation == OP_QUERY, busy && !out_valid, "query not taken up")
  `XYLI_ASSERT_NEXT(a_write_quiet, start && !busy && in_operation == OP_WRITE, !busy && !out_valid, "write item stalled or gave a result")

endmodule

bind xy_table_linear_interpolator xyli_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_operation(in_operation),
  .out_valid   (out_valid)
);

### dv/tb_xy_table_linear_interpolator.sv
`timescale 1ns / 100ps

module tb_xy_table_linear_interpolator;
  import xyli_pkg::*;

  localparam int MAX_POINTS = 16;
  // worst-case query latency with a full table
  localparam int RESULT_LATENCY = MAX_POINTS + 23;
  // cycles with neither an item nor a result taken before the run is abandoned
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 60;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_operation;
  logic [3:0]         in_point_index;
  logic signed [15:0] in_point_x;
  logic signed [15:0] in_point_y;
  logic signed [15:0] in_query_x;
  logic               out_valid;
  logic signed [15:0] out_result_y;
  logic               cfg_we;
  logic [4:0]         cfg_wdata;

  // shadow of the breakpoint table and the point count, kept in step with the block
  logic signed [15:0] table_x [MAX_POINTS];
  logic signed [15:0] table_y [MAX_POINTS];
  logic [4:0]         points_reg;

  // interpolated y values still owed by the block, oldest first
  logic signed [15:0] expected_y_q [$];
  logic signed [15:0] owed_y;

  int err_count;
  int idle_pct;
  int stall_cycles;
  int point_counts [PHASES];
  int idle_mix [3];

  xy_table_linear_interpolator #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_point_index(in_point_index),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_query_x    (in_query_x),
    .out_valid     (out_valid),
    .out_result_y  (out_result_y),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // a count of zero behaves as one point, anything past the table as a full table
  function automatic int eff_points();
    if (points_reg == 0) return 1;
    if (points_reg > MAX_POINTS) return MAX_POINTS;
    return int'(points_reg);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // linear interpolation over the points in use, clamped at both ends
  function automatic logic signed [15:0] interpolate_y(input logic signed [15:0] qx);
    int     last_i;
    int     c;
    bit     rising;
    longint x0, x1, y0, y1, num, den, full;
    last_i = eff_points() - 1;
    // direction is settled by the two end points alone; equal ends count as falling
    rising = table_x[0] < table_x[last_i];
    c = 0;
    // first breakpoint past the query, never looking at the last one
    while (c < last_i && !((rising && table_x[c] > qx) || (!rising && table_x[c] < qx)))
      c++;
    if (c == 0) return table_y[0];
    if (c >= last_i && ((rising && qx >= table_x[last_i]) ||
                        (!rising && qx <= table_x[last_i])))
      return table_y[last_i];
    x0 = longint'(table_x[c-1]);
    x1 = longint'(table_x[c]);
    y0 = longint'(table_y[c-1]);
    y1 = longint'(table_y[c]);
    den = x1 - x0;
    if (den == 0) return table_y[c-1];
    // product kept at 64 bits so the 33-bit intermediate cannot wrap
    num = (y1 - y0) * (longint'(qx) - x0);
    full = y0 + num / den;
    return full[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic signed [15:0] want,
                                 input logic signed [15:0] got);
    $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
    err_count++;
  endtask

  // outputs are read at the rising edge, before the block's own updates land
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_y_q.size() == 0) begin
        report_mismatch("result_y with no query outstanding", '0, out_result_y);
      end else begin
        owed_y = expected_y_q.pop_front();
        if (out_result_y !== owed_y)
          report_mismatch("result_y", owed_y, out_result_y);
      end
    end
  end

  // watchdog: any accepted item or result restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles with nothing accepted, %0d results owed",
                 stall_cycles, expected_y_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // present one item at the falling edge and hold it until the block takes it;
  // the shadow table and the owed results are updated at the accepting edge
  task automatic send_item(input logic op, input logic [3:0] idx,
                           input logic signed [15:0] px, input logic signed [15:0] py,
                           input logic signed [15:0] qx);
    @(negedge clk);
    // short random gaps, plus now and then a longer one that can outlast a whole query
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    if (idle_pct != 0 && $urandom_range(0, 24) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(5, 45)) @(negedge clk);
    end
    in_operation   = op;
    in_point_index = idx;
    in_point_x     = px;
    in_point_y     = py;
    in_query_x     = qx;
    start          = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE) begin
      table_x[idx] = px;
      table_y[idx] = py;
    end else begin
      expected_y_q.push_back(interpolate_y(qx));
    end
  endtask

  // unused fields of each item carry random bits so every port bit toggles
  task automatic write_point(input logic [3:0] idx, input logic signed [15:0] px,
                             input logic signed [15:0] py);
    send_item(OP_WRITE, idx, px, py, 16'($urandom));
  endtask

  task automatic query_at(input logic signed [15:0] qx);
    send_item(OP_QUERY, 4'($urandom), 16'($urandom), 16'($urandom), qx);
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_y_q.size() != 0) @(negedge clk);
  endtask

  // the point count is only rewritten with the block idle and nothing owed
  task automatic set_point_count(input logic [4:0] count);
    drain_results();
    repeat (RESULT_LATENCY) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = count;
    @(negedge clk);
    cfg_we     = 1'b0;
    cfg_wdata  = 5'($urandom);
    points_reg = count;
  endtask

  // a monotonic table over entries 0..n-1 with random content: sometimes spread
  // across the whole range, sometimes bunched, with repeated x values now and then
  task automatic write_table(input int n, input bit falling);
    int vals [MAX_POINTS];
    int centre, width, i, j, t;
    bit spread;
    logic signed [15:0] py;
    spread = 1'($urandom_range(0, 1));
    centre = int'($urandom_range(0, 65535)) - 32768;
    width  = $urandom_range(0, 4000);
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 6) == 0)
        vals[i] = vals[i-1];
      else if (spread)
        vals[i] = int'($urandom_range(0, 65535)) - 32768;
      else
        vals[i] = clamp16(centre + int'($urandom_range(0, width)) - width / 2);
    end
    // insertion sort, ascending
    for (i = 1; i < n; i++) begin
      t = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > t) begin
        vals[j+1] = vals[j];
        j--;
      end
      vals[j+1] = t;
    end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        py = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      else
        py = 16'($urandom);
      write_point(4'(i), 16'(vals[falling ? n - 1 - i : i]), py);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset count of two points, spanning the full x range with a full-scale
  // y swing so the product needs all of its width
  task automatic test_rising_two_point();
    write_point(4'd0, 16'sh8000, 16'sh7fff);
    write_point(4'd15, 16'sh7fff, 16'sh8000);
    write_point(4'd1, 16'sh7fff, 16'sh8000);
    query_at(16'sh8000);
    query_at(-16'sd32767);
    query_at(-16'sd1);
    query_at(16'sd0);
    query_at(16'sd1);
    query_at(16'sd32766);
    query_at(16'sh7fff);
  endtask

  // falling column: beyond the first end, on both ends, inside, beyond the last
  task automatic test_falling_two_point();
    write_point(4'd0, 16'sd1000, -16'sd500);
    write_point(4'd1, -16'sd1000, 16'sd700);
    query_at(16'sh7fff);
    query_at(16'sd1000);
    query_at(16'sd999);
    query_at(16'sd0);
    query_at(-16'sd333);
    query_at(-16'sd1000);
    query_at(16'sh8000);
  endtask

  // equal end x values: taken as a falling column
  task automatic test_equal_end_x();
    write_point(4'd1, 16'sd1000, 16'sd123);
    query_at(16'sd1000);
    query_at(16'sd999);
    query_at(16'sd1001);
  endtask

  // a count of zero acts as a single point: every query gives the first y
  task automatic test_single_point();
    set_point_count(5'd0);
    query_at(16'sh8000);
    query_at(16'sh7fff);
    query_at(16'sd5);
  endtask

  // phases of random tables, counts and queries under different idling mixes
  task automatic test_random_tables();
    int p, k, r, q, n, a, b, lo, hi;
    point_counts = '{16, 31, 1, 17, 0, 5, 16, 2, 12, 31, 8, 16};
    idle_mix     = '{0, 51, 32};
    // every entry is written once before any count above two is set
    idle_pct = 0;
    write_table(MAX_POINTS, 1'b0);
    for (p = 0; p < PHASES; p++) begin
      set_point_count(5'(point_counts[p]));
      idle_pct = idle_mix[p % 3];
      n = eff_points();
      write_table(n, 1'($urandom_range(0, 1)));
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          write_table(eff_points(), 1'($urandom_range(0, 1)));
        end else if (r < 12) begin
          // stray write that may break the ordering of the column
          write_point(4'($urandom), 16'($urandom), 16'($urandom));
        end else if (r < 14) begin
          drain_results();
        end else begin
          q = $urandom_range(0, 99);
          a = int'(table_x[$urandom_range(0, n - 1)]);
          if (q < 25) begin
            query_at(16'($urandom));
          end else if (q < 50) begin
            query_at(16'(a));
          end else if (q < 70) begin
            query_at(16'(clamp16(a + int'($urandom_range(0, 6)) - 3)));
          end else if (q < 90) begin
            // somewhere between two breakpoints picked at random
            b  = int'(table_x[$urandom_range(0, n - 1)]);
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            query_at(16'(lo + int'($urandom_range(0, hi - lo))));
          end else begin
            query_at($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_WRITE;
    in_point_index = '0;
    in_point_x     = '0;
    in_point_y     = '0;
    in_query_x     = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    err_count      = 0;
    stall_cycles   = 0;
    idle_pct       = 0;
    points_reg     = 5'd2;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_rising_two_point();
    test_falling_two_point();
    test_equal_end_x();
    test_single_point();
    test_random_tables();

    // let stragglers surface before the verdict
    drain_results();
    repeat (RESULT_LATENCY + 8) @(posedge clk);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
